/* hdl/hkst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hkst_pkg;

  // Table geometry; the slot count is a power of two so the home slot is a mask
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned HASH_MULT = 37;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_FREE,
    S_RESP
  } state_e;

  // Key store access, one read and one write port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
  } ram_req_t;

  // One result word
  typedef struct packed {
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] occ;
    status_e          status;
    logic [IDX_W-1:0] slot;
  } result_t;

  // Home slot: low bits of the 32-bit product key * 37
  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = key * KEY_W'(HASH_MULT);
    return prod[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/hkst_key_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hkst_key_ram (
  input  wire logic              clk_i,
  input  wire hkst_pkg::ram_req_t req_i,
  output logic [hkst_pkg::KEY_W-1:0] rdata_o
);

  logic [hkst_pkg::KEY_W-1:0] mem [hkst_pkg::SLOTS];
  logic [hkst_pkg::KEY_W-1:0] rdata_q;

  // Write one key
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/hkst_probe.sv */
`timescale 1ns / 1ps
`default_nettype none

module hkst_probe (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  output logic                            req_ready_o,
  input  wire logic [1:0]                 req_op_i,
  input  wire logic [hkst_pkg::KEY_W-1:0] req_key_i,
  output hkst_pkg::ram_req_t              ram_req_o,
  input  wire logic [hkst_pkg::KEY_W-1:0] ram_rdata_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output hkst_pkg::result_t               res_o
);

  hkst_pkg::state_e state_q, state_d;

  logic [hkst_pkg::KEY_W-1:0] key_q;
  hkst_pkg::op_e              op_q;
  logic [hkst_pkg::IDX_W-1:0] home_q;
  logic [hkst_pkg::IDX_W-1:0] cmp_idx_q;
  logic [hkst_pkg::IDX_W-1:0] cmp_cnt_q;
  logic [hkst_pkg::IDX_W-1:0] res_slot_q;
  hkst_pkg::status_e          res_status_q;

  logic [hkst_pkg::SLOTS-1:0] valid_q;
  logic [hkst_pkg::CNT_W-1:0] count_q, count_d;
  logic [hkst_pkg::CNT_W-1:0] peak_q, peak_d;

  logic                       accept;
  logic                       known_op;
  logic                       hit;
  logic                       last;
  logic                       has_room;
  logic                       commit;
  logic [hkst_pkg::IDX_W-1:0] req_home;

  assign req_home = hkst_pkg::home_slot(req_key_i);
  assign accept   = (state_q == hkst_pkg::S_IDLE) && req_valid_i;
  assign known_op = (req_op_i == hkst_pkg::OP_LOOKUP) || (req_op_i == hkst_pkg::OP_INSERT)
                 || (req_op_i == hkst_pkg::OP_REMOVE);

  // Shared compare unit: stored key against request key, behind the valid bit
  assign hit      = valid_q[cmp_idx_q] && (ram_rdata_i == key_q);
  assign last     = (cmp_cnt_q == hkst_pkg::IDX_W'(hkst_pkg::SLOTS - 1));
  assign has_room = (count_q < hkst_pkg::CNT_W'(hkst_pkg::SLOTS));
  assign commit   = (state_q == hkst_pkg::S_RESP) && res_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hkst_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = known_op ? hkst_pkg::S_MATCH : hkst_pkg::S_RESP;
        end
      end
      hkst_pkg::S_MATCH: begin
        if (hit) begin
          state_d = hkst_pkg::S_RESP;
        end else if (last) begin
          state_d = (op_q == hkst_pkg::OP_INSERT && has_room) ? hkst_pkg::S_FREE
                                                              : hkst_pkg::S_RESP;
        end
      end
      hkst_pkg::S_FREE: begin
        if (!valid_q[cmp_idx_q]) begin
          state_d = hkst_pkg::S_RESP;
        end
      end
      hkst_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = hkst_pkg::S_IDLE;
        end
      end
      default: state_d = hkst_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshakes and key store access
  always_comb begin
    req_ready_o       = 1'b0;
    res_valid_o       = 1'b0;
    ram_req_o.rd_en   = 1'b0;
    ram_req_o.rd_addr = cmp_idx_q + hkst_pkg::IDX_W'(1);
    ram_req_o.wr_en   = 1'b0;
    ram_req_o.wr_addr = res_slot_q;
    ram_req_o.wr_data = key_q;
    unique case (state_q)
      hkst_pkg::S_IDLE: begin
        req_ready_o       = 1'b1;
        ram_req_o.rd_en   = req_valid_i;
        ram_req_o.rd_addr = req_home;
      end
      hkst_pkg::S_MATCH: begin
        ram_req_o.rd_en = 1'b1;
      end
      hkst_pkg::S_FREE: begin
      end
      hkst_pkg::S_RESP: begin
        res_valid_o     = 1'b1;
        ram_req_o.wr_en = res_ready_i && (res_status_q == hkst_pkg::ST_INSERTED);
      end
      default: begin
      end
    endcase
  end

  // Counts after this request
  always_comb begin
    count_d = count_q;
    peak_d  = peak_q;
    if (res_status_q == hkst_pkg::ST_INSERTED) begin
      count_d = count_q + hkst_pkg::CNT_W'(1);
    end else if (res_status_q == hkst_pkg::ST_FOUND && op_q == hkst_pkg::OP_REMOVE
                 && count_q != '0) begin
      count_d = count_q - hkst_pkg::CNT_W'(1);
    end
    if (count_d > peak_q) begin
      peak_d = count_d;
    end
  end

  assign res_o.slot   = res_slot_q;
  assign res_o.status = res_status_q;
  assign res_o.occ    = count_d;
  assign res_o.peak   = peak_d;

  // State, valid bits and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hkst_pkg::S_IDLE;
      valid_q <= '0;
      count_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q <= count_d;
        peak_q  <= peak_d;
        if (res_status_q == hkst_pkg::ST_INSERTED) begin
          valid_q[res_slot_q] <= 1'b1;
        end else if (res_status_q == hkst_pkg::ST_FOUND && op_q == hkst_pkg::OP_REMOVE) begin
          valid_q[res_slot_q] <= 1'b0;
        end
      end
    end
  end

  // Probe datapath: one slot a cycle; a free slot exists whenever the count has room
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      hkst_pkg::S_IDLE: begin
        if (accept) begin
          key_q        <= req_key_i;
          op_q         <= hkst_pkg::op_e'(req_op_i);
          home_q       <= req_home;
          cmp_idx_q    <= req_home;
          cmp_cnt_q    <= '0;
          res_slot_q   <= '0;
          res_status_q <= hkst_pkg::ST_MISSING;
        end
      end
      hkst_pkg::S_MATCH: begin
        if (hit) begin
          res_slot_q   <= cmp_idx_q;
          res_status_q <= hkst_pkg::ST_FOUND;
        end else if (last) begin
          if (op_q == hkst_pkg::OP_INSERT) begin
            if (has_room) begin
              cmp_idx_q <= home_q;
            end else begin
              res_status_q <= hkst_pkg::ST_FULL;
            end
          end
        end else begin
          cmp_idx_q <= cmp_idx_q + hkst_pkg::IDX_W'(1);
          cmp_cnt_q <= cmp_cnt_q + hkst_pkg::IDX_W'(1);
        end
      end
      hkst_pkg::S_FREE: begin
        if (!valid_q[cmp_idx_q]) begin
          res_slot_q   <= cmp_idx_q;
          res_status_q <= hkst_pkg::ST_INSERTED;
        end else begin
          cmp_idx_q <= cmp_idx_q + hkst_pkg::IDX_W'(1);
        end
      end
      hkst_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/hashed_key_slot_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Hash table of 64 32-bit keys with linear probing from the home slot.
// Input stream s_axis: tuser carries the opcode (lookup, find-or-insert,
// remove), tdata the key. Output stream m_axis: one word per request with
// the slot, status, occupied count and peak count.
// One request is in flight at a time. The probe reads one stored key per
// cycle from the key memory and compares it in a single compare unit.
// The probe visits slots from the home slot up to a hit (1 to 64 slots).
// A miss visits all 64 slots; an insert miss with room left then scans the
// valid bits from the home slot up to the free slot. An unused opcode
// skips the probe and goes straight to the result.
// The result sits in an output register: the next request is accepted
// while it waits, and if the receiver stalls, the following result holds
// in the probe until the register frees up.
// Reset clears all valid bits and both counts at once; no clearing pass.
module hashed_key_slot_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // agent_key[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // slot_index[5:0], status[7:6],
                                           // occupied_count[14:8], peak_count[21:15]
);

  hkst_pkg::ram_req_t         ram_req;
  logic [hkst_pkg::KEY_W-1:0] ram_rdata;
  logic                       res_valid;
  logic                       res_ready;
  hkst_pkg::result_t          res;

  logic                       m_valid_q;
  hkst_pkg::result_t          m_res_q;

  hkst_key_ram u_key_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  hkst_probe u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (s_axis_tuser),
    .req_key_i   (s_axis_tdata),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_res_q.peak, m_res_q.occ, m_res_q.status, m_res_q.slot};

  // Counts stay ordered and bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_res_q.occ <= m_res_q.peak)
               && (m_res_q.peak <= hkst_pkg::CNT_W'(hkst_pkg::SLOTS)))
    else $error("result counts out of order or bound");

  // Misses and full answers carry slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_res_q.status == hkst_pkg::ST_MISSING
               || m_res_q.status == hkst_pkg::ST_FULL) |-> (m_res_q.slot == '0))
    else $error("slot index not zero on miss or full");

  // An accepted request always occupies the probe for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("probe ready right after accepting a request");

  // A fresh insert raises the count to at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_res_q.status == hkst_pkg::ST_INSERTED) |-> (m_res_q.occ != '0))
    else $error("insert reported with zero occupancy");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0]        OP_UNUSED    = 2'd3;
  localparam logic [31:0]       KEY_SCRAMBLE = 32'd37;
  localparam int                RAND_ITEMS   = 1550;
  localparam int                SEGMENT_LEN  = 150;
  localparam int                POOL_SIZE    = 128;
  localparam int                POOL_W       = $clog2(POOL_SIZE);
  localparam hkst_pkg::result_t UNPINNED     = '0;

  typedef struct {
    logic [1:0]        op;
    logic [31:0]       key;
    bit                pinned;
    hkst_pkg::result_t reply;
  } probe_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // agent_key[31:0]
  logic [1:0]  s_axis_tuser;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // slot_index[5:0], status[7:6],
                               // occupied_count[14:8], peak_count[21:15]

  // Shadow copy of the table contents
  logic [hkst_pkg::KEY_W-1:0] slot_key  [hkst_pkg::SLOTS];
  bit                         slot_used [hkst_pkg::SLOTS];
  int                         live_count;
  int                         high_water;

  hkst_pkg::result_t expected_replies[$];
  probe_row_t        opening_rows[$];
  logic [31:0]       key_pool[POOL_SIZE];
  int                mismatches;
  bit                steady;

  hashed_key_slot_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic hkst_pkg::result_t make_reply(input int slot,
                                                   input hkst_pkg::status_e st,
                                                   input int occ, input int peak);
    hkst_pkg::result_t r;
    r.slot   = hkst_pkg::IDX_W'(slot);
    r.status = st;
    r.occ    = hkst_pkg::CNT_W'(occ);
    r.peak   = hkst_pkg::CNT_W'(peak);
    return r;
  endfunction

  // Apply one request to the shadow table and return the word it produces
  function automatic hkst_pkg::result_t apply_request(input logic [1:0] op,
                                                      input logic [31:0] key);
    hkst_pkg::result_t          r;
    logic [31:0]                prod;
    logic [hkst_pkg::IDX_W-1:0] home;
    logic [hkst_pkg::IDX_W-1:0] idx;
    logic [hkst_pkg::IDX_W-1:0] hit_idx;
    logic [hkst_pkg::IDX_W-1:0] free_idx;
    bit                         hit_ok;
    bit                         free_ok;
    prod     = key * KEY_SCRAMBLE;
    home     = prod[hkst_pkg::IDX_W-1:0];
    hit_idx  = '0;
    free_idx = '0;
    hit_ok   = 1'b0;
    free_ok  = 1'b0;
    r.slot   = '0;
    r.status = hkst_pkg::ST_MISSING;
    if (op == hkst_pkg::OP_LOOKUP || op == hkst_pkg::OP_INSERT
        || op == hkst_pkg::OP_REMOVE) begin
      // Match probe over every slot from home
      for (int i = 0; i < int'(hkst_pkg::SLOTS); i++) begin
        idx = home + hkst_pkg::IDX_W'(i);
        if (!hit_ok && slot_used[idx] && slot_key[idx] == key) begin
          hit_ok  = 1'b1;
          hit_idx = idx;
        end
      end
      if (hit_ok) begin
        r.slot   = hit_idx;
        r.status = hkst_pkg::ST_FOUND;
        if (op == hkst_pkg::OP_REMOVE) begin
          slot_used[hit_idx] = 1'b0;
          if (live_count > 0) live_count--;
        end
      end else if (op == hkst_pkg::OP_INSERT) begin
        // Claim the first free slot from home unless the table is full
        if (live_count < int'(hkst_pkg::SLOTS)) begin
          for (int i = 0; i < int'(hkst_pkg::SLOTS); i++) begin
            idx = home + hkst_pkg::IDX_W'(i);
            if (!free_ok && !slot_used[idx]) begin
              free_ok  = 1'b1;
              free_idx = idx;
            end
          end
        end
        if (free_ok) begin
          slot_key[free_idx]  = key;
          slot_used[free_idx] = 1'b1;
          live_count++;
          if (live_count > high_water) high_water = live_count;
          r.slot   = free_idx;
          r.status = hkst_pkg::ST_INSERTED;
        end else begin
          r.status = hkst_pkg::ST_FULL;
        end
      end
    end
    r.occ  = hkst_pkg::CNT_W'(live_count);
    r.peak = hkst_pkg::CNT_W'(high_water);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Present one request, hold it until accepted, then queue its expected word
  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input bit pinned, input hkst_pkg::result_t pinned_reply);
    hkst_pkg::result_t predicted;
    while (!steady && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(op, key);
    expected_replies.push_back(pinned ? pinned_reply : predicted);
  endtask

  // Result side: check each accepted word, then choose the next stall
  always @(posedge clk_i) begin
    hkst_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[5:0] != want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", m_axis_tdata[5:0], want.slot));
        if (m_axis_tdata[7:6] != want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[7:6], want.status));
        if (m_axis_tdata[14:8] != want.occ)
          report_mismatch($sformatf("occupied %0d, want %0d", m_axis_tdata[14:8], want.occ));
        if (m_axis_tdata[21:15] != want.peak)
          report_mismatch($sformatf("peak %0d, want %0d", m_axis_tdata[21:15], want.peak));
        if (m_axis_tdata[23:22] != 2'b00)
          report_mismatch($sformatf("pad bits %b not zero", m_axis_tdata[23:22]));
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 8);
  end

  // Stimulus
  initial begin
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] base;
    int          mode;
    int          roll;
    mismatches    = 0;
    steady        = 1'b0;
    live_count    = 0;
    high_water    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;

    // Key 19 lands on the last slot, so 19 and 83 wrap the probe to slot 0;
    // keys differing by a multiple of 64 share a home slot.
    opening_rows = '{
      '{hkst_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, make_reply(0, hkst_pkg::ST_MISSING, 0, 0)},
      '{hkst_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, make_reply(0, hkst_pkg::ST_MISSING, 0, 0)},
      '{OP_UNUSED,           32'h1234_5678, 1'b1, make_reply(0, hkst_pkg::ST_MISSING, 0, 0)},
      '{hkst_pkg::OP_INSERT, 32'h0000_0000, 1'b1, make_reply(0, hkst_pkg::ST_INSERTED, 1, 1)},
      '{hkst_pkg::OP_INSERT, 32'h0000_0000, 1'b1, make_reply(0, hkst_pkg::ST_FOUND, 1, 1)},
      '{hkst_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, UNPINNED},
      '{hkst_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h0000_0040, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h0000_0080, 1'b0, UNPINNED},
      '{hkst_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, UNPINNED},
      '{hkst_pkg::OP_LOOKUP, 32'h0000_0080, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h0000_00C0, 1'b0, UNPINNED},
      '{hkst_pkg::OP_REMOVE, 32'h0000_0040, 1'b0, UNPINNED},
      '{hkst_pkg::OP_REMOVE, 32'h0000_0040, 1'b0, UNPINNED},
      '{hkst_pkg::OP_LOOKUP, 32'h0000_0040, 1'b0, UNPINNED},
      '{OP_UNUSED,           32'h0000_0000, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h8000_0000, 1'b0, UNPINNED},
      '{hkst_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h0000_0013, 1'b0, UNPINNED},
      '{hkst_pkg::OP_INSERT, 32'h0000_0053, 1'b0, UNPINNED},
      '{hkst_pkg::OP_LOOKUP, 32'h0000_0053, 1'b0, UNPINNED},
      '{hkst_pkg::OP_REMOVE, 32'h0000_0013, 1'b0, UNPINNED},
      '{hkst_pkg::OP_LOOKUP, 32'h0000_0053, 1'b0, UNPINNED}
    };

    // Key pool in groups of eight that share a home slot
    for (int g = 0; g < POOL_SIZE / 8; g++) begin
      base = $urandom;
      for (int n = 0; n < 8; n++) key_pool[POOL_W'(g*8 + n)] = base + 32'(n * 64);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (opening_rows[i])
      send_request(opening_rows[i].op, opening_rows[i].key,
                   opening_rows[i].pinned, opening_rows[i].reply);

    // Random traffic in segments: mixed churn, fill to full, drain
    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 600 && i < 900);
      mode   = (i / SEGMENT_LEN) % 3;
      roll   = $urandom_range(99);
      case (mode)
        0: begin
          op = (roll < 35) ? hkst_pkg::OP_INSERT : (roll < 65) ? hkst_pkg::OP_LOOKUP :
               (roll < 95) ? hkst_pkg::OP_REMOVE : OP_UNUSED;
        end
        1: begin
          op = (roll < 85) ? hkst_pkg::OP_INSERT : (roll < 95) ? hkst_pkg::OP_LOOKUP :
               (roll < 98) ? hkst_pkg::OP_REMOVE : OP_UNUSED;
        end
        default: begin
          op = (roll < 60) ? hkst_pkg::OP_REMOVE : (roll < 80) ? hkst_pkg::OP_LOOKUP :
               (roll < 95) ? hkst_pkg::OP_INSERT : OP_UNUSED;
        end
      endcase
      key = ($urandom_range(99) < 8) ? $urandom
                                     : key_pool[POOL_W'($urandom_range(POOL_SIZE - 1))];
      send_request(op, key, 1'b0, UNPINNED);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then give any stray word time to show up
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
